// File: rtl/bzinv_pkg.sv
`default_nettype none

package bzinv_pkg;

  // number formats
  localparam int T_FRAC_BITS = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int T_WIDTH     = T_FRAC_BITS + 1;
  localparam int TOL_WIDTH   = 16;
  localparam int DIFF_WIDTH  = VALUE_WIDTH + 1;
  localparam int PROD_WIDTH  = DIFF_WIDTH + T_WIDTH;
  localparam int SCALE_WIDTH = PROD_WIDTH - T_FRAC_BITS;

  localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC_BITS;

  // stream payload widths
  localparam int IN_DATA_WIDTH  = 5 * VALUE_WIDTH;
  localparam int OUT_DATA_WIDTH = ((T_WIDTH + 7) / 8) * 8;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // de casteljau step codes
  typedef logic [2:0] step_t;
  localparam step_t STEP_L0  = 3'd0;
  localparam step_t STEP_L1  = 3'd1;
  localparam step_t STEP_L2  = 3'd2;
  localparam step_t STEP_M0  = 3'd3;
  localparam step_t STEP_M1  = 3'd4;
  localparam step_t STEP_FIN = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  init;
    logic  mid;
    logic  lerp_diff;
    logic  lerp_mul;
    logic  lerp_add;
    step_t step;
    logic  update;
    logic  res_rev;
    logic  res_mid;
    logic  res_bottom;
    logic  out_load;
  } bzinv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cubic;
    logic reversed;
    logic span_gt1;
    logic hit;
    logic out_full;
  } bzinv_status_t;

endpackage

`default_nettype wire

// File: rtl/bzinv_ctrl.sv
`default_nettype none

module bzinv_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire bzinv_pkg::bzinv_status_t st,
  output bzinv_pkg::bzinv_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_MID   = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  bzinv_pkg::step_t step;
  bzinv_pkg::step_t step_next;

  // state and step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= bzinv_pkg::STEP_L0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  // sequencing of one search
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        if (st.reversed) begin
          cmd.res_rev = 1'b1;
          state_next  = S_DONE;
        end else begin
          state_next = S_MID;
        end
      end
      S_MID: begin
        if (st.span_gt1) begin
          cmd.mid    = 1'b1;
          step_next  = bzinv_pkg::STEP_L0;
          state_next = S_DIFF;
        end else begin
          cmd.res_bottom = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DIFF: begin
        cmd.lerp_diff = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.lerp_mul = 1'b1;
        state_next   = S_ADD;
      end
      S_ADD: begin
        cmd.lerp_add = 1'b1;
        if (step == bzinv_pkg::STEP_FIN) begin
          state_next = S_CHECK;
        end else begin
          // quadratic skips L2 and the M0/M1 steps
          if (!st.cubic && step == bzinv_pkg::STEP_L1) begin
            step_next = bzinv_pkg::STEP_FIN;
          end else begin
            step_next = step + 3'd1;
          end
          state_next = S_DIFF;
        end
      end
      S_CHECK: begin
        if (st.hit) begin
          cmd.res_mid = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.update = 1'b1;
          state_next = S_MID;
        end
      end
      S_DONE: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bzinv_dp.sv
`default_nettype none

module bzinv_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bzinv_pkg::bzinv_cmd_t                cmd,
  output bzinv_pkg::bzinv_status_t                  st,
  input  wire logic                                 in_op,
  input  wire bzinv_pkg::value_t                    in_target,
  input  wire bzinv_pkg::value_t                    in_start,
  input  wire bzinv_pkg::value_t                    in_first,
  input  wire bzinv_pkg::value_t                    in_second,
  input  wire bzinv_pkg::value_t                    in_end,
  input  wire logic                                 cfg_we,
  input  wire logic [bzinv_pkg::TOL_WIDTH-1:0]      cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [bzinv_pkg::T_WIDTH-1:0]             out_t,
  output logic                                      out_rev
);

  logic                                  cubic;
  bzinv_pkg::value_t                     x;
  bzinv_pkg::value_t                     p0, p1, p2, p3;
  bzinv_pkg::value_t                     l0, l1, l2, m0, m1, test;
  logic [bzinv_pkg::T_WIDTH-1:0]         bottom, top, mid;
  bzinv_pkg::value_t                     lp;
  logic                                  neg;
  logic [bzinv_pkg::DIFF_WIDTH-1:0]      mag;
  logic [bzinv_pkg::PROD_WIDTH-1:0]      prod;
  logic [bzinv_pkg::T_WIDTH-1:0]         res_t;
  logic                                  res_rev;
  logic [bzinv_pkg::TOL_WIDTH-1:0]       tol;

  bzinv_pkg::value_t                     hi_b;
  bzinv_pkg::value_t                     x_clamped;
  logic [bzinv_pkg::T_WIDTH-1:0]         span;
  logic [bzinv_pkg::T_WIDTH:0]           mid_sum;
  bzinv_pkg::value_t                     op_p, op_q;
  logic signed [bzinv_pkg::DIFF_WIDTH-1:0] diff;
  logic [bzinv_pkg::DIFF_WIDTH-1:0]      diff_mag;
  logic [bzinv_pkg::SCALE_WIDTH-1:0]     scaled;
  logic signed [bzinv_pkg::SCALE_WIDTH-1:0] scaled_s;
  logic signed [bzinv_pkg::SCALE_WIDTH-1:0] lerp_sum;
  bzinv_pkg::value_t                     lerp_val;
  logic signed [bzinv_pkg::DIFF_WIDTH-1:0] err;
  logic [bzinv_pkg::DIFF_WIDTH-1:0]      aerr;

  // range check and target clamp
  assign hi_b      = cubic ? p3 : p2;
  assign x_clamped = (x < p0) ? p0 : ((x > hi_b) ? hi_b : x);

  // interval span and midpoint
  assign span    = top - bottom;
  assign mid_sum = {1'b0, bottom} + {1'b0, top};

  // operand select for the shared lerp unit
  always_comb begin
    unique case (cmd.step)
      bzinv_pkg::STEP_L0:  begin op_p = p0; op_q = p1; end
      bzinv_pkg::STEP_L1:  begin op_p = p1; op_q = p2; end
      bzinv_pkg::STEP_L2:  begin op_p = p2; op_q = p3; end
      bzinv_pkg::STEP_M0:  begin op_p = l0; op_q = l1; end
      bzinv_pkg::STEP_M1:  begin op_p = l1; op_q = l2; end
      bzinv_pkg::STEP_FIN: begin
        op_p = cubic ? m0 : l0;
        op_q = cubic ? m1 : l1;
      end
      default: begin op_p = p0; op_q = p1; end
    endcase
  end

  // lerp stage one: difference and magnitude
  assign diff     = bzinv_pkg::DIFF_WIDTH'(op_q) - bzinv_pkg::DIFF_WIDTH'(op_p);
  assign diff_mag = diff[bzinv_pkg::DIFF_WIDTH-1] ? bzinv_pkg::DIFF_WIDTH'(-diff)
                                                  : bzinv_pkg::DIFF_WIDTH'(diff);

  // lerp stage three: drop fraction, restore sign, add base
  assign scaled   = prod[bzinv_pkg::PROD_WIDTH-1:bzinv_pkg::T_FRAC_BITS];
  assign scaled_s = neg ? -$signed(scaled) : $signed(scaled);
  assign lerp_sum = bzinv_pkg::SCALE_WIDTH'(lp) + scaled_s;
  assign lerp_val = lerp_sum[bzinv_pkg::VALUE_WIDTH-1:0];

  // error against the clamped target
  assign err  = bzinv_pkg::DIFF_WIDTH'(test) - bzinv_pkg::DIFF_WIDTH'(x);
  assign aerr = err[bzinv_pkg::DIFF_WIDTH-1] ? bzinv_pkg::DIFF_WIDTH'(-err)
                                             : bzinv_pkg::DIFF_WIDTH'(err);

  // status to the controller
  always_comb begin
    st.cubic    = cubic;
    st.reversed = hi_b < p0;
    st.span_gt1 = span > bzinv_pkg::T_WIDTH'(1);
    st.hit      = aerr < bzinv_pkg::DIFF_WIDTH'(tol);
    st.out_full = out_valid && !out_ready;
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= bzinv_pkg::TOL_WIDTH'(1);
    end else if (cfg_we) begin
      tol <= cfg_data;
    end
  end

  // input capture and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cubic <= in_op;
      x     <= in_target;
      p0    <= in_start;
      p1    <= in_first;
      p2    <= in_second;
      p3    <= in_end;
    end
    if (cmd.init) begin
      x      <= x_clamped;
      bottom <= '0;
      top    <= bzinv_pkg::T_ONE;
    end
    if (cmd.mid) begin
      mid <= mid_sum[bzinv_pkg::T_WIDTH:1];
    end
    if (cmd.update) begin
      if (x > test) begin
        bottom <= mid;
      end else begin
        top <= mid;
      end
    end
  end

  // shared lerp unit
  always_ff @(posedge clk) begin
    if (cmd.lerp_diff) begin
      lp  <= op_p;
      neg <= diff[bzinv_pkg::DIFF_WIDTH-1];
      mag <= diff_mag;
    end
    if (cmd.lerp_mul) begin
      prod <= bzinv_pkg::PROD_WIDTH'(mag) * bzinv_pkg::PROD_WIDTH'(mid);
    end
    if (cmd.lerp_add) begin
      unique case (cmd.step)
        bzinv_pkg::STEP_L0:  l0   <= lerp_val;
        bzinv_pkg::STEP_L1:  l1   <= lerp_val;
        bzinv_pkg::STEP_L2:  l2   <= lerp_val;
        bzinv_pkg::STEP_M0:  m0   <= lerp_val;
        bzinv_pkg::STEP_M1:  m1   <= lerp_val;
        bzinv_pkg::STEP_FIN: test <= lerp_val;
        default: ;
      endcase
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.res_rev) begin
      res_t   <= '0;
      res_rev <= 1'b1;
    end else if (cmd.res_mid) begin
      res_t   <= mid;
      res_rev <= 1'b0;
    end else if (cmd.res_bottom) begin
      res_t   <= bottom;
      res_rev <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_t   <= res_t;
      out_rev <= res_rev;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bezier_x_to_t_bisection.sv
// result: t of zero for a reversed range, else the midpoint of the step that accepts it,
//   or the interval bottom once the span no longer exceeds one
// throughput: one item at a time; each step runs 3 or 6 lerps through one shared
//   multiply unit plus a midpoint and a compare state
// the next input beat is taken while the previous result waits in the output register
// reset: synchronous, clears control and output valid, tolerance returns to 1
`default_nettype none

module bezier_x_to_t_bisection (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // target_value, start_value, first_control, second_control, end_value
  input  wire logic [bzinv_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,
  // op
  input  wire logic [0:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // param_t, zero fill
  output logic [bzinv_pkg::OUT_DATA_WIDTH-1:0]       m_axis_tdata,
  // bounds_reversed
  output logic [0:0]                                 m_axis_tuser,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bzinv_pkg::TOL_WIDTH-1:0]       cfg_data
);

  localparam int VW = bzinv_pkg::VALUE_WIDTH;

  bzinv_pkg::bzinv_cmd_t         cmd;
  bzinv_pkg::bzinv_status_t      st;
  logic [bzinv_pkg::T_WIDTH-1:0] out_t;
  logic                          out_rev;

  assign cfg_ready = !rst;

  bzinv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bzinv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_op     (s_axis_tuser[0]),
    .in_target (s_axis_tdata[0*VW +: VW]),
    .in_start  (s_axis_tdata[1*VW +: VW]),
    .in_first  (s_axis_tdata[2*VW +: VW]),
    .in_second (s_axis_tdata[3*VW +: VW]),
    .in_end    (s_axis_tdata[4*VW +: VW]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_t     (out_t),
    .out_rev   (out_rev)
  );

  // output payload packing
  assign m_axis_tdata    = bzinv_pkg::OUT_DATA_WIDTH'(out_t);
  assign m_axis_tuser[0] = out_rev;

endmodule

`default_nettype wire

// File: rtl/bzinv_chk.sv
`default_nettype none

module bzinv_chk (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_axis_tvalid,
  input wire logic                                  s_axis_tready,
  input wire logic                                  m_axis_tvalid,
  input wire logic                                  m_axis_tready,
  input wire logic [bzinv_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,
  input wire logic [0:0]                            m_axis_tuser
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // reversed range reports t of zero
  a_rev_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[bzinv_pkg::T_WIDTH-1:0] == '0))
    else $error("reversed range with nonzero t");

  // t never exceeds one
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[bzinv_pkg::T_FRAC_BITS] ||
                       (m_axis_tdata[bzinv_pkg::T_FRAC_BITS-1:0] == '0)))
    else $error("t above one");

  // one item in the search at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken during a search");

endmodule

bind bezier_x_to_t_bisection bzinv_chk u_bzinv_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
